[design/ta2_pkg.sv]
// Shared types, constants and arctangent tables for the table_atan2_binary_angle block.
package ta2_pkg;

	// Input and magnitude widths.
	localparam int unsigned INPUT_WIDTH = 16;
	localparam int unsigned MAG_W       = INPUT_WIDTH + 1;

	// Ratio b/a in Q1.16, one integer bit so that a ratio of one fits.
	localparam int unsigned RATIO_FRAC_BITS = 16;
	localparam int unsigned RATIO_W         = RATIO_FRAC_BITS + 1;

	// Divider organization: one leading compare, then this many steps per stage.
	localparam int unsigned DIV_STAGES     = 4;
	localparam int unsigned STEPS_PER_STAGE = RATIO_FRAC_BITS / DIV_STAGES;

	// Table of segments and its index and fraction widths.
	localparam int unsigned TABLE_SEGMENTS = 32;
	localparam int unsigned SEG_BITS       = $clog2(TABLE_SEGMENTS);
	localparam int unsigned IDX_W          = SEG_BITS + 1;
	localparam int unsigned FRAC_W         = RATIO_FRAC_BITS;
	localparam int unsigned ROM_W          = 22;
	localparam int unsigned SLOPE_W        = 17;

	// Internal angle: Q.16 binary units, base of up to 128 units.
	localparam int unsigned TBL_FRAC_BITS = 16;
	localparam int unsigned BASE_W        = 9;
	localparam int unsigned ANGLE_W       = BASE_W + TBL_FRAC_BITS;
	localparam int unsigned DEG_W         = ANGLE_W + 6;
	localparam int unsigned OUT_W         = 17;

	// Rounding shifts toward the two output formats.
	localparam int unsigned UNITS_SHIFT = TBL_FRAC_BITS - 8;
	localparam int unsigned DEG_SHIFT   = TBL_FRAC_BITS - 8 + 5;

	// Base angles in whole binary units.
	localparam logic signed [BASE_W-1:0] BASE_ZERO    = 9'sd0;
	localparam logic signed [BASE_W-1:0] BASE_POS_90  = 9'sd64;
	localparam logic signed [BASE_W-1:0] BASE_NEG_90  = -9'sd64;
	localparam logic signed [BASE_W-1:0] BASE_POS_180 = 9'sd128;
	localparam logic signed [BASE_W-1:0] BASE_NEG_180 = -9'sd128;

	// Folding result that rides along the divider.
	typedef struct packed {
		logic                     origin;
		logic                     sub;
		logic signed [BASE_W-1:0] base;
	} side_t;

	// atan(k/32) in Q6.16 binary units.
	localparam logic [ROM_W-1:0] ATAN_ROM [0:TABLE_SEGMENTS] = '{
		22'd0,       22'd83416,   22'd166669,  22'd249600,
		22'd332050,  22'd413869,  22'd494912,  22'd575043,
		22'd654136,  22'd732076,  22'd808756,  22'd884085,
		22'd957981,  22'd1030375, 22'd1101209, 22'd1170436,
		22'd1238021, 22'd1303938, 22'd1368170, 22'd1430711,
		22'd1491559, 22'd1550722, 22'd1608214, 22'd1664052,
		22'd1718262, 22'd1770869, 22'd1821906, 22'd1871405,
		22'd1919403, 22'd1965938, 22'd2011047, 22'd2054772,
		22'd2097152
	};

	// Difference to the next entry; the last entry has slope zero.
	localparam logic [SLOPE_W-1:0] ATAN_SLOPE [0:TABLE_SEGMENTS] = '{
		17'd83416, 17'd83253, 17'd82931, 17'd82450,
		17'd81819, 17'd81043, 17'd80131, 17'd79093,
		17'd77940, 17'd76680, 17'd75329, 17'd73896,
		17'd72394, 17'd70834, 17'd69227, 17'd67585,
		17'd65917, 17'd64232, 17'd62541, 17'd60848,
		17'd59163, 17'd57492, 17'd55838, 17'd54210,
		17'd52607, 17'd51037, 17'd49499, 17'd47998,
		17'd46535, 17'd45109, 17'd43725, 17'd42380,
		17'd0
	};

endpackage

[design/ta2_div.sv]
// Pipelined restoring divider giving floor(b * 2^16 / a) for b <= a.
module ta2_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	output logic                            in_rdy,
	input  logic [ta2_pkg::MAG_W-1:0]       dvd,
	input  logic [ta2_pkg::MAG_W-1:0]       dvs,
	input  ta2_pkg::side_t                  in_side,
	output logic                            out_vld,
	input  logic                            out_rdy,
	output logic [ta2_pkg::RATIO_W-1:0]     quo,
	output ta2_pkg::side_t                  out_side
);

	typedef struct packed {
		logic [ta2_pkg::MAG_W-1:0]   rem;
		logic [ta2_pkg::RATIO_W-1:0] quo;
	} div_st_t;

	// A few restoring steps: shift the remainder, subtract the divisor when it fits.
	function automatic div_st_t div_steps(input div_st_t st, input logic [ta2_pkg::MAG_W-1:0] d);
		div_st_t                   res;
		logic [ta2_pkg::MAG_W:0]   sh;
		logic                      bit_q;
		res = st;
		for (int i = 0; i < ta2_pkg::STEPS_PER_STAGE; i++) begin
			sh    = {res.rem, 1'b0};
			bit_q = (sh >= {1'b0, d});
			if (bit_q) begin
				sh = sh - {1'b0, d};
			end
			res.rem = sh[ta2_pkg::MAG_W-1:0];
			res.quo = {res.quo[ta2_pkg::RATIO_W-2:0], bit_q};
		end
		return res;
	endfunction

	logic                        vld_s   [ta2_pkg::DIV_STAGES];
	div_st_t                     st_s    [ta2_pkg::DIV_STAGES];
	logic [ta2_pkg::MAG_W-1:0]   dvs_s   [ta2_pkg::DIV_STAGES];
	ta2_pkg::side_t              side_s  [ta2_pkg::DIV_STAGES];
	logic                        rdy     [ta2_pkg::DIV_STAGES+1];
	div_st_t                     st_in;

	// The integer bit of the quotient is set only when b equals a.
	always_comb begin
		st_in.quo = '0;
		st_in.rem = dvd;
		if (dvd >= dvs) begin
			st_in.quo = ta2_pkg::RATIO_W'(1);
			st_in.rem = dvd - dvs;
		end
	end

	assign rdy[ta2_pkg::DIV_STAGES] = out_rdy;
	assign in_rdy = rdy[0];

	for (genvar g = 0; g < ta2_pkg::DIV_STAGES; g++) begin : g_stage
		logic                      vld_in;
		div_st_t                   st_prev;
		logic [ta2_pkg::MAG_W-1:0] dvs_prev;
		ta2_pkg::side_t            side_prev;

		if (g == 0) begin : g_first
			assign vld_in    = in_vld;
			assign st_prev   = st_in;
			assign dvs_prev  = dvs;
			assign side_prev = in_side;
		end else begin : g_next
			assign vld_in    = vld_s[g-1];
			assign st_prev   = st_s[g-1];
			assign dvs_prev  = dvs_s[g-1];
			assign side_prev = side_s[g-1];
		end

		assign rdy[g] = ~vld_s[g] | rdy[g+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (rdy[g]) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g] && vld_in) begin
				st_s[g]   <= div_steps(st_prev, dvs_prev);
				dvs_s[g]  <= dvs_prev;
				side_s[g] <= side_prev;
			end
		end
	end

	assign out_vld  = vld_s[ta2_pkg::DIV_STAGES-1];
	assign quo      = st_s[ta2_pkg::DIV_STAGES-1].quo;
	assign out_side = side_s[ta2_pkg::DIV_STAGES-1];

endmodule

[design/table_atan2_binary_angle.sv]
// Top level of the four-quadrant arctangent with table interpolation.
//
// Usage: each input word carries a signed x_in, y_in pair and yields exactly one
// output word with the angle in binary units (256 per turn) and in degrees, both
// with 8 fraction bits. The origin gives an angle of zero.
// Both channels use valid and stall. A word moves at a rising edge where valid
// is high and stall is low; in_stall is driven here, out_stall by the receiver.
// The datapath is a ten-stage pipeline: octant folding, four divider stages of
// four quotient bits each, table read, interpolation multiply, base add,
// units rounding with the times-45 product, and the output register. One new
// word can enter in every cycle while the receiver does not stall, so the
// throughput is then one word per clock.
// Each stage holds its own valid bit and advances when it is empty or the next
// stage can take its word. When the receiver stalls, the output word is held
// and the stages behind it keep filling empty slots until the pipeline is full;
// only then is in_stall raised. Nothing is dropped or repeated.
// The asynchronous reset clears every valid bit, leaving the pipeline empty and
// ready for a word as soon as reset is released.
module table_atan2_binary_angle (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ta2_pkg::INPUT_WIDTH-1:0] x_in,
	input  logic signed [ta2_pkg::INPUT_WIDTH-1:0] y_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ta2_pkg::OUT_W-1:0]    angle_units,
	output logic signed [ta2_pkg::OUT_W-1:0]    angle_degrees
);

	// ---------------------------------------------------------------
	// Ready chain: a stage can load when it is empty or its word leaves.
	// ---------------------------------------------------------------
	logic vld_s1, vld_tab_s6, vld_mul_s7, vld_q_s8, vld_m_s9, vld_out_s10;
	logic rdy_s1, rdy_s6, rdy_s7, rdy_s8, rdy_s9, rdy_s10;
	logic div_in_rdy, div_out_vld;

	assign rdy_s10  = ~vld_out_s10 | ~out_stall;
	assign rdy_s9   = ~vld_m_s9 | rdy_s10;
	assign rdy_s8   = ~vld_q_s8 | rdy_s9;
	assign rdy_s7   = ~vld_mul_s7 | rdy_s8;
	assign rdy_s6   = ~vld_tab_s6 | rdy_s7;
	assign rdy_s1   = ~vld_s1 | div_in_rdy;
	assign in_stall = ~rdy_s1;

	// ---------------------------------------------------------------
	// Stage 1: fold the point into the first octant. The larger magnitude
	// becomes the divisor, the smaller one the dividend. Ties go to the
	// octant along the x axis, so the negative x axis reads +180 degrees.
	// ---------------------------------------------------------------
	logic signed [ta2_pkg::MAG_W-1:0] xs, ys, nx, ny;
	logic signed [ta2_pkg::MAG_W-1:0] fa, fb;
	ta2_pkg::side_t                   fside;
	logic [ta2_pkg::MAG_W-1:0]        a_s1, b_s1;
	ta2_pkg::side_t                   side_s1;

	assign xs = {x_in[ta2_pkg::INPUT_WIDTH-1], x_in};
	assign ys = {y_in[ta2_pkg::INPUT_WIDTH-1], y_in};
	assign nx = -xs;
	assign ny = -ys;

	always_comb begin
		fside.origin = (x_in == '0) && (y_in == '0);
		if (!xs[ta2_pkg::MAG_W-1]) begin
			if (!ys[ta2_pkg::MAG_W-1]) begin
				if (xs >= ys) begin
					fa = xs; fb = ys; fside.base = ta2_pkg::BASE_ZERO;   fside.sub = 1'b0;
				end else begin
					fa = ys; fb = xs; fside.base = ta2_pkg::BASE_POS_90; fside.sub = 1'b1;
				end
			end else begin
				if (xs >= ny) begin
					fa = xs; fb = ny; fside.base = ta2_pkg::BASE_ZERO;   fside.sub = 1'b1;
				end else begin
					fa = ny; fb = xs; fside.base = ta2_pkg::BASE_NEG_90; fside.sub = 1'b0;
				end
			end
		end else begin
			if (!ys[ta2_pkg::MAG_W-1]) begin
				if (nx >= ys) begin
					fa = nx; fb = ys; fside.base = ta2_pkg::BASE_POS_180; fside.sub = 1'b1;
				end else begin
					fa = ys; fb = nx; fside.base = ta2_pkg::BASE_POS_90;  fside.sub = 1'b0;
				end
			end else begin
				if (nx >= ny) begin
					fa = nx; fb = ny; fside.base = ta2_pkg::BASE_NEG_180; fside.sub = 1'b0;
				end else begin
					fa = ny; fb = nx; fside.base = ta2_pkg::BASE_NEG_90;  fside.sub = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			a_s1    <= fa;
			b_s1    <= fb;
			side_s1 <= fside;
		end
	end

	// ---------------------------------------------------------------
	// Stages 2 to 5: ratio = floor(b * 2^16 / a), in [0, 1] as Q1.16.
	// At the origin the divisor is zero; the quotient is ignored then.
	// ---------------------------------------------------------------
	logic [ta2_pkg::RATIO_W-1:0] ratio;
	ta2_pkg::side_t              div_side;

	ta2_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_rdy   (div_in_rdy),
		.dvd      (b_s1),
		.dvs      (a_s1),
		.in_side  (side_s1),
		.out_vld  (div_out_vld),
		.out_rdy  (rdy_s6),
		.quo      (ratio),
		.out_side (div_side)
	);

	// ---------------------------------------------------------------
	// Stage 6: table read. The top bits of the ratio pick the segment and
	// the low bits, scaled up to 16 bits, are the interpolation fraction.
	// A ratio of exactly one selects the last entry with a zero fraction.
	// ---------------------------------------------------------------
	logic [ta2_pkg::IDX_W-1:0]   seg_idx;
	logic [ta2_pkg::FRAC_W-1:0]  seg_frac;
	logic [ta2_pkg::ROM_W-1:0]   base_s6;
	logic [ta2_pkg::SLOPE_W-1:0] slope_s6;
	logic [ta2_pkg::FRAC_W-1:0]  frac_s6;
	ta2_pkg::side_t              side_s6;

	assign seg_idx  = ratio[ta2_pkg::RATIO_W-1:ta2_pkg::RATIO_FRAC_BITS-ta2_pkg::SEG_BITS];
	assign seg_frac = {ratio[ta2_pkg::RATIO_FRAC_BITS-ta2_pkg::SEG_BITS-1:0],
		ta2_pkg::SEG_BITS'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_tab_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_tab_s6 <= div_out_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && div_out_vld) begin
			base_s6  <= ta2_pkg::ATAN_ROM[seg_idx];
			slope_s6 <= ta2_pkg::ATAN_SLOPE[seg_idx];
			frac_s6  <= seg_frac;
			side_s6  <= div_side;
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: linear interpolation, base + floor(frac * slope / 2^16).
	// ---------------------------------------------------------------
	logic [ta2_pkg::FRAC_W+ta2_pkg::SLOPE_W-1:0] interp_prod;
	logic [ta2_pkg::ROM_W-1:0]                   oct_s7;
	ta2_pkg::side_t                              side_s7;

	assign interp_prod = frac_s6 * slope_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_mul_s7 <= 1'b0;
		end else if (rdy_s7) begin
			vld_mul_s7 <= vld_tab_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_tab_s6) begin
			oct_s7  <= base_s6 + ta2_pkg::ROM_W'(interp_prod >> ta2_pkg::RATIO_FRAC_BITS);
			side_s7 <= side_s6;
		end
	end

	// ---------------------------------------------------------------
	// Stage 8: unfold, adding the octant angle to the base or taking it
	// away. The origin is forced to zero here.
	// ---------------------------------------------------------------
	logic signed [ta2_pkg::ANGLE_W-1:0] base_q16, oct_ext, angle_s8;

	assign base_q16 = {side_s7.base, ta2_pkg::TBL_FRAC_BITS'(0)};
	assign oct_ext  = $signed(ta2_pkg::ANGLE_W'(oct_s7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q_s8 <= 1'b0;
		end else if (rdy_s8) begin
			vld_q_s8 <= vld_mul_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s8 && vld_mul_s7) begin
			if (side_s7.origin) begin
				angle_s8 <= '0;
			end else if (side_s7.sub) begin
				angle_s8 <= base_q16 - oct_ext;
			end else begin
				angle_s8 <= base_q16 + oct_ext;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 9: round to binary units (ties away from zero) and form the
	// angle times 45 for the degree scale, using shifts and adds.
	// ---------------------------------------------------------------
	logic                               ang_neg;
	logic [ta2_pkg::ANGLE_W-1:0]        ang_mag;
	logic [ta2_pkg::ANGLE_W-1:0]        units_rnd;
	logic [ta2_pkg::OUT_W-1:0]          units_mag;
	logic signed [ta2_pkg::DEG_W-1:0]   ang_wide, ang_x45;
	logic signed [ta2_pkg::OUT_W-1:0]   units_s9;
	logic signed [ta2_pkg::DEG_W-1:0]   x45_s9;

	assign ang_neg   = angle_s8[ta2_pkg::ANGLE_W-1];
	assign ang_mag   = ang_neg ? ta2_pkg::ANGLE_W'(-angle_s8) : ta2_pkg::ANGLE_W'(angle_s8);
	assign units_rnd = (ang_mag + (ta2_pkg::ANGLE_W'(1) << (ta2_pkg::UNITS_SHIFT - 1)))
		>> ta2_pkg::UNITS_SHIFT;
	assign units_mag = units_rnd[ta2_pkg::OUT_W-1:0];
	assign ang_wide  = ta2_pkg::DEG_W'(angle_s8);
	assign ang_x45   = (ang_wide <<< 5) + (ang_wide <<< 3) + (ang_wide <<< 2) + ang_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m_s9 <= 1'b0;
		end else if (rdy_s9) begin
			vld_m_s9 <= vld_q_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s9 && vld_q_s8) begin
			units_s9 <= ang_neg ? -$signed(units_mag) : $signed(units_mag);
			x45_s9   <= ang_x45;
		end
	end

	// ---------------------------------------------------------------
	// Stage 10: round the degree value and hold the output word.
	// ---------------------------------------------------------------
	logic                           deg_neg;
	logic [ta2_pkg::DEG_W-1:0]      deg_mag;
	logic [ta2_pkg::DEG_W-1:0]      deg_rnd;
	logic [ta2_pkg::OUT_W-1:0]      deg_out_mag;
	logic signed [ta2_pkg::OUT_W-1:0] units_s10, degs_s10;

	assign deg_neg     = x45_s9[ta2_pkg::DEG_W-1];
	assign deg_mag     = deg_neg ? ta2_pkg::DEG_W'(-x45_s9) : ta2_pkg::DEG_W'(x45_s9);
	assign deg_rnd     = (deg_mag + (ta2_pkg::DEG_W'(1) << (ta2_pkg::DEG_SHIFT - 1)))
		>> ta2_pkg::DEG_SHIFT;
	assign deg_out_mag = deg_rnd[ta2_pkg::OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s10 <= 1'b0;
		end else if (rdy_s10) begin
			vld_out_s10 <= vld_m_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s10 && vld_m_s9) begin
			units_s10 <= units_s9;
			degs_s10  <= deg_neg ? -$signed(deg_out_mag) : $signed(deg_out_mag);
		end
	end

	assign out_valid     = vld_out_s10;
	assign angle_units   = units_s10;
	assign angle_degrees = degs_s10;

endmodule

[tb/table_atan2_binary_angle_test.sv]
// Self-checking testbench for the table_atan2_binary_angle arctangent block.
module table_atan2_binary_angle_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Port widths, taken from the design package.
	localparam int unsigned INPUT_WIDTH = ta2_pkg::INPUT_WIDTH;
	localparam int unsigned OUT_W       = ta2_pkg::OUT_W;

	// Fixed-point layout of the angle computation.
	localparam int SEGMENTS   = 32;
	localparam int RATIO_BITS = 16;
	localparam int ANGLE_FRAC = 16;

	// Base angles of the folded octants, in whole binary units.
	localparam longint QUARTER_TURN = 64;
	localparam longint HALF_TURN    = 128;

	// The pipeline is ten stages deep.
	localparam int PIPE_LATENCY = 9;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;

	// A correct run only idles during receiver stall runs, sender gaps and the
	// settle time after a drain, so this limit leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	// atan(k/32) scaled to 2^16 fractional binary units, rounded to nearest.
	localparam longint SEG_ANGLE [0:SEGMENTS] = '{
		0, 83416, 166669, 249600, 332050, 413869, 494912, 575043,
		654136, 732076, 808756, 884085, 957981, 1030375, 1101209, 1170436,
		1238021, 1303938, 1368170, 1430711, 1491559, 1550722, 1608214, 1664052,
		1718262, 1770869, 1821906, 1871405, 1919403, 1965938, 2011047, 2054772,
		2097152
	};

	// Receiver behavior: never stall, stall on a light random mix, or stall in long runs.
	typedef enum logic [1:0] {
		RECV_FREE,
		RECV_LIGHT,
		RECV_HEAVY
	} recv_mode_t;

	// One expected output word, together with the input that caused it.
	typedef struct {
		logic signed [INPUT_WIDTH-1:0] x;
		logic signed [INPUT_WIDTH-1:0] y;
		logic signed [OUT_W-1:0]       units;
		logic signed [OUT_W-1:0]       degrees;
	} angle_word_t;

	logic clk;
	logic arst_n = 1'b0;

	// Every block input holds a known value from time zero.
	logic                          in_valid  = 1'b0;
	logic signed [INPUT_WIDTH-1:0] x_in      = '0;
	logic signed [INPUT_WIDTH-1:0] y_in      = '0;
	logic                          out_stall = 1'b0;
	logic                          in_stall;
	logic                          out_valid;
	logic signed [OUT_W-1:0]       angle_units;
	logic signed [OUT_W-1:0]       angle_degrees;

	// Angles still owed by the block, oldest first.
	angle_word_t pending_angles[$];

	int mismatch_count = 0;
	int idle_cycles = 0;

	// Sender pacing: words go out in bursts; gaps are off during streaming phases.
	bit sender_gaps = 1'b1;
	int burst_left = 0;

	// Receiver pacing state.
	recv_mode_t recv_mode = RECV_FREE;
	bit stall_hold = 1'b0;
	int stall_run = 0;

	table_atan2_binary_angle dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_in         (x_in),
		.y_in         (y_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.angle_units  (angle_units),
		.angle_degrees(angle_degrees)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Divide by a power of two, rounding to nearest with ties away from zero.
	function automatic longint round_away(longint v, int sh);
		longint half;
		half = longint'(1) <<< (sh - 1);
		if (v >= 0) begin
			return (v + half) >>> sh;
		end
		return -((-v + half) >>> sh);
	endfunction

	// Computes the angle the block should return for one coordinate pair.
	function automatic angle_word_t predict_angle(logic signed [INPUT_WIDTH-1:0] x,
			logic signed [INPUT_WIDTH-1:0] y);
		angle_word_t w;
		longint xs, ys, a, b, base, q, ratio, scaled, idx, frac, slope, t;
		bit sub;
		w.x = x;
		w.y = y;
		xs = x;
		ys = y;
		if (xs == 0 && ys == 0) begin
			w.units = '0;
			w.degrees = '0;
			return w;
		end
		// Fold into the first octant. Ties go to the octant next to the x axis,
		// which is why the negative x axis lands on +128 units.
		if (xs >= 0) begin
			if (ys >= 0) begin
				if (xs >= ys) begin
					a = xs; b = ys; base = 0; sub = 1'b0;
				end else begin
					a = ys; b = xs; base = QUARTER_TURN; sub = 1'b1;
				end
			end else begin
				if (xs >= -ys) begin
					a = xs; b = -ys; base = 0; sub = 1'b1;
				end else begin
					a = -ys; b = xs; base = -QUARTER_TURN; sub = 1'b0;
				end
			end
		end else begin
			if (ys >= 0) begin
				if (-xs >= ys) begin
					a = -xs; b = ys; base = HALF_TURN; sub = 1'b1;
				end else begin
					a = ys; b = -xs; base = QUARTER_TURN; sub = 1'b0;
				end
			end else begin
				if (-xs >= -ys) begin
					a = -xs; b = -ys; base = -HALF_TURN; sub = 1'b0;
				end else begin
					a = -ys; b = -xs; base = -QUARTER_TURN; sub = 1'b1;
				end
			end
		end
		// Truncated ratio, then a segment index and an interpolation fraction.
		// A ratio of one selects the last entry with no slope.
		ratio = (b <<< RATIO_BITS) / a;
		scaled = ratio * SEGMENTS;
		idx = scaled >>> RATIO_BITS;
		frac = scaled & ((longint'(1) <<< RATIO_BITS) - 1);
		if (idx >= SEGMENTS) begin
			idx = SEGMENTS;
			frac = 0;
		end
		slope = (idx < SEGMENTS) ? SEG_ANGLE[idx + 1] - SEG_ANGLE[idx] : 0;
		t = SEG_ANGLE[idx] + ((frac * slope) >>> RATIO_BITS);
		q = base <<< ANGLE_FRAC;
		q = sub ? q - t : q + t;
		// Degrees are units times 360/256, that is times 45 and over 32.
		w.units = OUT_W'(round_away(q, ANGLE_FRAC - 8));
		w.degrees = OUT_W'(round_away(q * 45, ANGLE_FRAC - 8 + 5));
		return w;
	endfunction

	// Presents one word at a falling edge and holds it until the block takes it.
	// Between bursts the valid line drops for a random gap. The word is only
	// lowered here, never in the same step in which the next word raises it.
	task automatic send_word(logic signed [INPUT_WIDTH-1:0] x, logic signed [INPUT_WIDTH-1:0] y);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		x_in <= x;
		y_in <= y;
		// Sample the stall at the rising edge, before the edge's updates land.
		do begin
			@(posedge clk);
		end while (in_stall);
		pending_angles.push_back(predict_angle(x, y));
	endtask

	// Stops sending and waits until every owed angle has come out, then lets the
	// pipeline sit empty for a while. The watchdog bounds the wait.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_angles.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Axes, diagonals, the corners of the input range and the folding corner
	// cases, with a receiver that never stalls and no gaps.
	task automatic test_directed();
		sender_gaps = 1'b0;
		recv_mode = RECV_FREE;
		send_word(16'sd0, 16'sd0);            // origin gives zero
		send_word(16'sd1, 16'sd0);
		send_word(16'sd0, 16'sd1);
		send_word(16'sd0, -16'sd1);
		send_word(-16'sd1, 16'sd0);           // negative x axis gives +180
		send_word(-16'sd32768, 16'sd0);
		send_word(16'sd32767, 16'sd0);
		send_word(16'sd0, -16'sd32768);
		send_word(16'sd0, 16'sd32767);
		send_word(16'sd32767, 16'sd32767);    // ratio of one on every diagonal
		send_word(-16'sd32768, -16'sd32768);
		send_word(16'sd5, 16'sd5);
		send_word(-16'sd5, 16'sd5);
		send_word(16'sd5, -16'sd5);
		send_word(-16'sd5, -16'sd5);
		send_word(-16'sd32768, -16'sd1);      // just below the negative x axis
		send_word(-16'sd32768, 16'sd1);       // just above it
		send_word(-16'sd32767, -16'sd1);
		send_word(-16'sd32768, 16'sd32767);
		send_word(16'sd32767, -16'sd32768);
		send_word(-16'sd1, -16'sd1);
		send_word(16'sd32767, 16'sd1);
		send_word(16'sd1, -16'sd32768);
		send_word(16'sh5555, -16'sh2AAB);
		drain_pipeline();
	endtask

	// Coordinates drawn over the whole 16-bit range, so every input bit toggles.
	task automatic test_random_full(int count);
		sender_gaps = 1'b1;
		recv_mode = RECV_LIGHT;
		repeat (count) begin
			send_word(INPUT_WIDTH'($urandom), INPUT_WIDTH'($urandom));
		end
		drain_pipeline();
	endtask

	// Small magnitudes hit ties, axes and the origin often.
	task automatic test_small_vectors(int count);
		sender_gaps = 1'b1;
		recv_mode = RECV_HEAVY;
		repeat (count) begin
			send_word(INPUT_WIDTH'($urandom_range(0, 16)) - 16'sd8,
				INPUT_WIDTH'($urandom_range(0, 16)) - 16'sd8);
		end
		drain_pipeline();
	endtask

	// Points close to an octant boundary: a diagonal or one of the axes.
	task automatic test_octant_edges(int count);
		logic signed [INPUT_WIDTH-1:0] x, y, d;
		sender_gaps = 1'b1;
		recv_mode = RECV_LIGHT;
		repeat (count) begin
			x = INPUT_WIDTH'($urandom);
			d = INPUT_WIDTH'($urandom_range(0, 6)) - 16'sd3;
			case ($urandom_range(0, 3))
				0: begin
					y = x + d;
				end
				1: begin
					y = -x + d;
				end
				2: begin
					y = d;
				end
				default: begin
					y = x;
					x = d;
				end
			endcase
			send_word(x, y);
		end
		drain_pipeline();
	endtask

	// Back-to-back words with a receiver that never stalls: one word per clock.
	task automatic test_full_rate(int count);
		sender_gaps = 1'b0;
		recv_mode = RECV_FREE;
		repeat (count) begin
			send_word(INPUT_WIDTH'($urandom), INPUT_WIDTH'($urandom));
		end
		drain_pipeline();
	endtask

	// Back-to-back words against long receiver stalls, so the pipeline fills
	// and the input stall is raised and released many times.
	task automatic test_backpressure(int count);
		sender_gaps = 1'b0;
		recv_mode = RECV_HEAVY;
		repeat (count) begin
			send_word(INPUT_WIDTH'($urandom), INPUT_WIDTH'($urandom));
		end
		drain_pipeline();
	endtask

	// Receiver stall pattern, driven at the falling edge.
	always @(negedge clk) begin
		case (recv_mode)
			RECV_LIGHT: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			RECV_HEAVY: begin
				if (stall_run == 0) begin
					stall_hold = !stall_hold;
					stall_run = stall_hold ? $urandom_range(1, 24) : $urandom_range(1, 8);
				end
				stall_run--;
				out_stall <= stall_hold;
			end
			default: begin
				out_stall <= 1'b0;
			end
		endcase
	end

	// Every output word taken is checked against the oldest owed angle.
	always @(posedge clk) begin
		angle_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_angles.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("unexpected output word: units %0d degrees %0d",
						angle_units, angle_degrees);
				end
			end else begin
				w = pending_angles.pop_front();
				if (angle_units !== w.units || angle_degrees !== w.degrees) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display({"mismatch for x %0d y %0d: units exp %0d got %0d,",
							" degrees exp %0d got %0d"},
							w.x, w.y, w.units, angle_units, w.degrees, angle_degrees);
					end
				end
			end
		end
	end

	// Watchdog: ends the run once no word has moved on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// Reset once, released at a falling edge.
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_full(600);
		test_small_vectors(400);
		test_octant_edges(500);
		test_full_rate(300);
		test_backpressure(300);

		if (mismatch_count == 0 && pending_angles.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
